/* rtl/twg_pkg.sv */
// shared types, constants and the sine table of the table waveform generator
package twg_pkg;

    // sample phase
    localparam int unsigned SAMPLES = 32;
    localparam int unsigned IDX_W   = $clog2(SAMPLES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES - 1);

    // field and register widths
    localparam int unsigned SEL_W    = 2;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned OFS_W    = 8;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned TAB_W    = 12;

    // datapath widths
    localparam int unsigned SCALE_W     = PERIOD_W + PCT_W;
    localparam int unsigned QUO_W       = 17;
    localparam int unsigned NUM_W       = 28;
    localparam int unsigned RECIP_W     = 25;
    localparam int unsigned RECIP_SHIFT = 28;
    localparam int unsigned PROD_W      = NUM_W + RECIP_W;
    localparam int unsigned REM_W       = QUO_W + TAB_W;
    localparam int unsigned LEVEL_W     = 19;
    localparam int unsigned HI_W        = 12;

    // divisors, rounding terms and their reciprocals
    localparam int unsigned DIV_PCT  = 200;
    localparam int unsigned DIV_SINE = 4095;
    localparam int unsigned DIV_TRI  = SAMPLES / 2 - 1;
    localparam int unsigned RND_SINE = 2047;
    localparam int unsigned RND_TRI  = DIV_TRI / 2;
    localparam logic [RECIP_W-1:0] RECIP_PCT  = RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_PCT);
    localparam logic [RECIP_W-1:0] RECIP_SINE = RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_SINE);
    localparam logic [RECIP_W-1:0] RECIP_TRI  = RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_TRI);

    // register limits
    localparam logic [PCT_W-1:0] PCT_MIN  = PCT_W'(1);
    localparam logic [PCT_W-1:0] PCT_MAX  = PCT_W'(100);
    localparam logic [PCT_W-1:0] DUTY_MIN = PCT_W'(1);
    localparam logic [PCT_W-1:0] DUTY_MAX = PCT_W'(99);
    localparam logic signed [OFS_W-1:0] OFS_MIN = -8'sd100;
    localparam logic signed [OFS_W-1:0] OFS_MAX = 8'sd100;

    // square high count: idx < (32*duty + 50)/100
    localparam int unsigned HI_SCALE = 100;
    localparam int unsigned HI_MUL   = SAMPLES;
    localparam int unsigned HI_RND   = 50;

    // reset values
    localparam logic [PERIOD_W-1:0]     PERIOD_RST = PERIOD_W'(479);
    localparam logic [PCT_W-1:0]        AMP_RST    = PCT_W'(80);
    localparam logic signed [OFS_W-1:0] OFS_RST    = '0;
    localparam logic [PCT_W-1:0]        DUTY_RST   = PCT_W'(50);

    typedef enum logic [SEL_W-1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_TRI      = 2'd1,
        SHAPE_SQUARE   = 2'd2,
        SHAPE_SINE_ALT = 2'd3
    } t_wave;

    typedef enum logic [2:0] {
        REG_WAVE   = 3'd0,
        REG_PERIOD = 3'd1,
        REG_AMP    = 3'd2,
        REG_OFS    = 3'd3,
        REG_DUTY   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_wave                     wave;
        logic [PERIOD_W-1:0]       period;
        logic [PCT_W-1:0]          amp_pct;
        logic signed [OFS_W-1:0]   ofs_pct;
        logic [PCT_W-1:0]          high_pct;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PROD,
        OP_QUO_MID,
        OP_FIX_MID,
        OP_QUO_AMP,
        OP_FIX_AMP,
        OP_WAVE,
        OP_QUO_WAVE,
        OP_FIX_WAVE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic accept;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_QUO_MID,
        ST_FIX_MID,
        ST_QUO_AMP,
        ST_FIX_AMP,
        ST_WAVE,
        ST_QUO_WAVE,
        ST_FIX_WAVE,
        ST_EMIT
    } t_state;

    // 12-bit sine table over one period
    function automatic logic [TAB_W-1:0] sine_rom(input logic [IDX_W-1:0] idx);
        logic [TAB_W-1:0] val;
        case (idx)
            5'd0:  val = 12'd2048;
            5'd1:  val = 12'd2447;
            5'd2:  val = 12'd2831;
            5'd3:  val = 12'd3185;
            5'd4:  val = 12'd3495;
            5'd5:  val = 12'd3750;
            5'd6:  val = 12'd3939;
            5'd7:  val = 12'd4056;
            5'd8:  val = 12'd4095;
            5'd9:  val = 12'd4056;
            5'd10: val = 12'd3939;
            5'd11: val = 12'd3750;
            5'd12: val = 12'd3495;
            5'd13: val = 12'd3185;
            5'd14: val = 12'd2831;
            5'd15: val = 12'd2447;
            5'd16: val = 12'd2048;
            5'd17: val = 12'd1649;
            5'd18: val = 12'd1265;
            5'd19: val = 12'd911;
            5'd20: val = 12'd601;
            5'd21: val = 12'd346;
            5'd22: val = 12'd157;
            5'd23: val = 12'd40;
            5'd24: val = 12'd0;
            5'd25: val = 12'd40;
            5'd26: val = 12'd157;
            5'd27: val = 12'd346;
            5'd28: val = 12'd601;
            5'd29: val = 12'd911;
            5'd30: val = 12'd1265;
            5'd31: val = 12'd1649;
            default: val = 12'd2048;
        endcase
        return val;
    endfunction

endpackage

/* rtl/twg_regs.sv */
// configuration register file behind the apb-style port
module twg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twg_pkg::ADDR_W-1:0]   paddr,
    input  logic [twg_pkg::DATA_W-1:0]   pwdata,
    output logic [twg_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output twg_pkg::t_cfg                o_cfg
);

    twg_pkg::t_wave                            r_wave;
    logic [twg_pkg::PERIOD_W-1:0]              r_period;
    logic [twg_pkg::PCT_W-1:0]                 r_amp;
    logic signed [twg_pkg::OFS_W-1:0]          r_ofs;
    logic [twg_pkg::PCT_W-1:0]                 r_duty;
    logic                                      wr_en;
    twg_pkg::t_reg_idx                         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = twg_pkg::t_reg_idx'(paddr[4:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave   <= twg_pkg::SHAPE_SINE;
            r_period <= twg_pkg::PERIOD_RST;
            r_amp    <= twg_pkg::AMP_RST;
            r_ofs    <= twg_pkg::OFS_RST;
            r_duty   <= twg_pkg::DUTY_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                twg_pkg::REG_WAVE:   r_wave   <= twg_pkg::t_wave'(pwdata[twg_pkg::SEL_W-1:0]);
                twg_pkg::REG_PERIOD: r_period <= pwdata[twg_pkg::PERIOD_W-1:0];
                twg_pkg::REG_AMP:    r_amp    <= pwdata[twg_pkg::PCT_W-1:0];
                twg_pkg::REG_OFS:    r_ofs    <= $signed(pwdata[twg_pkg::OFS_W-1:0]);
                twg_pkg::REG_DUTY:   r_duty   <= pwdata[twg_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            twg_pkg::REG_WAVE:   prdata = twg_pkg::DATA_W'(r_wave);
            twg_pkg::REG_PERIOD: prdata = twg_pkg::DATA_W'(r_period);
            twg_pkg::REG_AMP:    prdata = twg_pkg::DATA_W'(r_amp);
            twg_pkg::REG_OFS:    prdata = twg_pkg::DATA_W'($unsigned(r_ofs));
            twg_pkg::REG_DUTY:   prdata = twg_pkg::DATA_W'(r_duty);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = '{wave: r_wave, period: r_period, amp_pct: r_amp,
                     ofs_pct: r_ofs, high_pct: r_duty};

endmodule

/* rtl/twg_ctrl.sv */
// sequencer that steps the datapath through one sample computation
module twg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  twg_pkg::t_dp_sts  i_sts,
    output twg_pkg::t_dp_cmd  o_cmd
);

    twg_pkg::t_state r_state;
    twg_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= twg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.op     = twg_pkg::OP_NONE;
        o_in_stall   = 1'b1;
        unique case (r_state)
            twg_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = twg_pkg::ST_PROD;
                end
            end
            twg_pkg::ST_PROD: begin
                o_cmd.op = twg_pkg::OP_PROD;
                n_state  = twg_pkg::ST_QUO_MID;
            end
            twg_pkg::ST_QUO_MID: begin
                o_cmd.op = twg_pkg::OP_QUO_MID;
                n_state  = twg_pkg::ST_FIX_MID;
            end
            twg_pkg::ST_FIX_MID: begin
                o_cmd.op = twg_pkg::OP_FIX_MID;
                n_state  = twg_pkg::ST_QUO_AMP;
            end
            twg_pkg::ST_QUO_AMP: begin
                o_cmd.op = twg_pkg::OP_QUO_AMP;
                n_state  = twg_pkg::ST_FIX_AMP;
            end
            twg_pkg::ST_FIX_AMP: begin
                o_cmd.op = twg_pkg::OP_FIX_AMP;
                n_state  = twg_pkg::ST_WAVE;
            end
            twg_pkg::ST_WAVE: begin
                o_cmd.op = twg_pkg::OP_WAVE;
                n_state  = twg_pkg::ST_QUO_WAVE;
            end
            twg_pkg::ST_QUO_WAVE: begin
                o_cmd.op = twg_pkg::OP_QUO_WAVE;
                n_state  = twg_pkg::ST_FIX_WAVE;
            end
            twg_pkg::ST_FIX_WAVE: begin
                o_cmd.op = twg_pkg::OP_FIX_WAVE;
                n_state  = twg_pkg::ST_EMIT;
            end
            twg_pkg::ST_EMIT: begin
                // wait until the output register can take the sample
                if (i_sts.out_free) begin
                    o_cmd.op = twg_pkg::OP_EMIT;
                    n_state  = twg_pkg::ST_IDLE;
                end
            end
            default: n_state = twg_pkg::ST_IDLE;
        endcase
    end

endmodule

/* rtl/twg_dp.sv */
// datapath: phase counter, level scaling, reciprocal divider and output register
module twg_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  twg_pkg::t_cfg                   i_cfg,
    input  twg_pkg::t_dp_cmd                i_cmd,
    output twg_pkg::t_dp_sts                o_sts,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [twg_pkg::PERIOD_W-1:0]    o_compare_value,
    output logic [twg_pkg::IDX_W-1:0]       o_sample_position,
    output logic                            o_period_end
);

    localparam int unsigned IDX_W   = twg_pkg::IDX_W;
    localparam int unsigned QUO_W   = twg_pkg::QUO_W;
    localparam int unsigned NUM_W   = twg_pkg::NUM_W;
    localparam int unsigned PROD_W  = twg_pkg::PROD_W;
    localparam int unsigned REM_W   = twg_pkg::REM_W;
    localparam int unsigned LEVEL_W = twg_pkg::LEVEL_W;
    localparam int unsigned SCALE_W = twg_pkg::SCALE_W;
    localparam int unsigned TAB_W   = twg_pkg::TAB_W;
    localparam int unsigned PCT_W   = twg_pkg::PCT_W;
    localparam int unsigned HI_W    = twg_pkg::HI_W;
    localparam int unsigned PW      = twg_pkg::PERIOD_W;

    // control and payload registers
    logic                        r_out_valid;
    logic [IDX_W-1:0]            r_phase;
    logic [IDX_W-1:0]            r_idx;
    logic [SCALE_W-1:0]          r_pm;
    logic [SCALE_W-1:0]          r_pa;
    logic [QUO_W-1:0]            r_q0;
    logic signed [LEVEL_W-1:0]   r_mid;
    logic [PW-1:0]               r_amp;
    logic [NUM_W-1:0]            r_num;
    logic [QUO_W-1:0]            r_wq;
    logic [PW-1:0]               r_cmp;
    logic [IDX_W-1:0]            r_pos;
    logic                        r_end;

    // combinational terms
    logic [IDX_W-1:0]            idx_sel;
    logic [PCT_W-1:0]            pp_cl;
    logic [PCT_W-1:0]            duty_cl;
    logic signed [7:0]           ofs_cl;
    logic                        ofs_neg;
    logic [PCT_W-1:0]            ofs_mag;
    logic                        is_tri;
    logic                        is_square;
    logic [3:0]                  tri_n;
    logic [NUM_W-1:0]            div_x;
    logic [twg_pkg::RECIP_W-1:0] div_m;
    logic [TAB_W-1:0]            div_d;
    logic [PROD_W-1:0]           prod;
    logic [REM_W-1:0]            q_times_d;
    logic [REM_W-1:0]            rem;
    logic [QUO_W-1:0]            q_fix;
    logic [TAB_W-1:0]            mul_b;
    logic [NUM_W-2:0]            amp_mul;
    logic [NUM_W-1:0]            rnd;
    logic [NUM_W-1:0]            n_num;
    logic signed [LEVEL_W-1:0]   half;
    logic signed [LEVEL_W-1:0]   q_s;
    logic signed [LEVEL_W-1:0]   n_mid;
    logic signed [LEVEL_W-1:0]   amp_s;
    logic signed [LEVEL_W-1:0]   lvl_lo;
    logic signed [LEVEL_W-1:0]   lvl_hi;
    logic signed [LEVEL_W-1:0]   lvl;
    logic signed [LEVEL_W-1:0]   top_s;
    logic [PW-1:0]               n_cmp;
    logic [HI_W-1:0]             hi_lhs;
    logic [HI_W-1:0]             hi_rhs;
    logic                        sq_high;

    // sample index with restart
    assign idx_sel = i_restart ? '0 : r_phase;

    // register clamps
    always_comb begin
        pp_cl = i_cfg.amp_pct;
        if (pp_cl < twg_pkg::PCT_MIN) pp_cl = twg_pkg::PCT_MIN;
        if (pp_cl > twg_pkg::PCT_MAX) pp_cl = twg_pkg::PCT_MAX;
        duty_cl = i_cfg.high_pct;
        if (duty_cl < twg_pkg::DUTY_MIN) duty_cl = twg_pkg::DUTY_MIN;
        if (duty_cl > twg_pkg::DUTY_MAX) duty_cl = twg_pkg::DUTY_MAX;
        ofs_cl = i_cfg.ofs_pct;
        if (ofs_cl < twg_pkg::OFS_MIN) ofs_cl = twg_pkg::OFS_MIN;
        if (ofs_cl > twg_pkg::OFS_MAX) ofs_cl = twg_pkg::OFS_MAX;
    end

    assign ofs_neg   = ofs_cl[7];
    assign ofs_mag   = ofs_neg ? PCT_W'(-ofs_cl) : PCT_W'(ofs_cl);
    assign is_tri    = (i_cfg.wave == twg_pkg::SHAPE_TRI);
    assign is_square = (i_cfg.wave == twg_pkg::SHAPE_SQUARE);

    // triangle step: rises on the first half, mirrors on the second
    assign tri_n = r_idx[IDX_W-1] ? ~r_idx[3:0] : r_idx[3:0];

    // divider operand selection
    always_comb begin
        case (i_cmd.op) inside
            twg_pkg::OP_QUO_MID, twg_pkg::OP_FIX_MID: begin
                div_x = NUM_W'(r_pm);
                div_m = twg_pkg::RECIP_PCT;
                div_d = TAB_W'(twg_pkg::DIV_PCT);
            end
            twg_pkg::OP_QUO_AMP, twg_pkg::OP_FIX_AMP: begin
                div_x = NUM_W'(r_pa);
                div_m = twg_pkg::RECIP_PCT;
                div_d = TAB_W'(twg_pkg::DIV_PCT);
            end
            default: begin
                div_x = r_num;
                div_m = is_tri ? twg_pkg::RECIP_TRI : twg_pkg::RECIP_SINE;
                div_d = is_tri ? TAB_W'(twg_pkg::DIV_TRI) : TAB_W'(twg_pkg::DIV_SINE);
            end
        endcase
    end

    // reciprocal estimate, then one correction step
    assign prod      = PROD_W'(div_x) * PROD_W'(div_m);
    assign q_times_d = REM_W'(r_q0) * REM_W'(div_d);
    assign rem       = REM_W'(div_x) - q_times_d;
    assign q_fix     = r_q0 + QUO_W'(rem >= REM_W'(div_d));

    // mid level from half period and signed offset term
    assign half  = $signed(LEVEL_W'(i_cfg.period[PW-1:1]));
    assign q_s   = $signed(LEVEL_W'(q_fix));
    assign n_mid = ofs_neg ? (half - q_s) : (half + q_s);

    // wave numerator: 2*amp*term plus rounding
    assign mul_b   = is_tri ? TAB_W'(tri_n) : twg_pkg::sine_rom(r_idx);
    assign amp_mul = (NUM_W-1)'(r_amp) * (NUM_W-1)'(mul_b);
    assign rnd     = is_tri ? NUM_W'(twg_pkg::RND_TRI) : NUM_W'(twg_pkg::RND_SINE);
    assign n_num   = {amp_mul, 1'b0} + rnd;

    // square high window: 100*(idx+1) <= 32*duty + 50
    assign hi_lhs  = HI_W'({1'b0, r_idx} + (IDX_W+1)'(1)) * HI_W'(twg_pkg::HI_SCALE);
    assign hi_rhs  = HI_W'(duty_cl) * HI_W'(twg_pkg::HI_MUL) + HI_W'(twg_pkg::HI_RND);
    assign sq_high = (hi_lhs <= hi_rhs);

    // final level and clamp to 0..period
    assign amp_s  = $signed(LEVEL_W'(r_amp));
    assign lvl_lo = r_mid - amp_s;
    assign lvl_hi = r_mid + amp_s;
    assign top_s  = $signed(LEVEL_W'(i_cfg.period));
    always_comb begin
        if (is_square) begin
            lvl = sq_high ? lvl_hi : lvl_lo;
        end else begin
            lvl = lvl_lo + $signed(LEVEL_W'(r_wq));
        end
        if (lvl < 0) begin
            n_cmp = '0;
        end else if (lvl > top_s) begin
            n_cmp = i_cfg.period;
        end else begin
            n_cmp = lvl[PW-1:0];
        end
    end

    // phase counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.accept) begin
            r_phase <= idx_sel + IDX_W'(1);
        end
    end

    // computation registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= idx_sel;
        end
        case (i_cmd.op)
            twg_pkg::OP_PROD: begin
                r_pm <= SCALE_W'(i_cfg.period) * SCALE_W'(ofs_mag);
                r_pa <= SCALE_W'(i_cfg.period) * SCALE_W'(pp_cl);
            end
            twg_pkg::OP_QUO_MID,
            twg_pkg::OP_QUO_AMP,
            twg_pkg::OP_QUO_WAVE: r_q0 <= prod[twg_pkg::RECIP_SHIFT +: QUO_W];
            twg_pkg::OP_FIX_MID:  r_mid <= n_mid;
            twg_pkg::OP_FIX_AMP:  r_amp <= q_fix[PW-1:0];
            twg_pkg::OP_WAVE:     r_num <= n_num;
            twg_pkg::OP_FIX_WAVE: r_wq <= q_fix;
            twg_pkg::OP_EMIT: begin
                r_cmp <= n_cmp;
                r_pos <= r_idx;
                r_end <= (r_idx == twg_pkg::IDX_LAST);
            end
            default: ;
        endcase
    end

    // output valid: set on emit, cleared when the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == twg_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_compare_value   = r_cmp;
    assign o_sample_position = r_pos;
    assign o_period_end      = r_end;

endmodule

/* rtl/table_waveform_generator_core.sv */
// top level of the table waveform generator
//
// Each input transaction is one sample strobe; its restart bit returns the
// phase to sample 0 first. Each strobe yields one output transaction with
// the PWM compare value, the sample position (0..31) and a period-end flag.
// Channels use valid/stall: a transaction completes on a clock edge with
// valid high and stall low. The apb-style port holds wave select, period,
// amplitude, offset and duty at byte addresses 0, 4, 8, 12 and 16.
//
// One sample is in work at a time and the sequencer walks nine steps
// through a shared reciprocal divider (mid level, amplitude, wave term).
// Its emit step waits for a free output register and loads it; o_out_valid
// is registered and set by that step. A new strobe is taken only after the
// emit step, when the sequencer is back in idle.
// While the receiver stalls the result holds in the output register; the
// next sample is still taken and computed, then waits until the register
// frees. Reset (synchronous, active low) zeroes the phase, empties the
// output register and loads the register defaults.
module table_waveform_generator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample strobe channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_restart,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [twg_pkg::PERIOD_W-1:0]  o_compare_value,
    output logic [twg_pkg::IDX_W-1:0]     o_sample_position,
    output logic                          o_period_end,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twg_pkg::ADDR_W-1:0]    paddr,
    input  logic [twg_pkg::DATA_W-1:0]    pwdata,
    output logic [twg_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    twg_pkg::t_cfg    cfg;
    twg_pkg::t_dp_cmd cmd;
    twg_pkg::t_dp_sts sts;

    // configuration registers
    twg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer
    twg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    twg_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_restart         (i_restart),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_compare_value   (o_compare_value),
        .o_sample_position (o_sample_position),
        .o_period_end      (o_period_end)
    );

endmodule

/* rtl/twg_checker.sv */
// port-level checks for the table waveform generator, bound to the top level
module twg_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [twg_pkg::PERIOD_W-1:0]  o_compare_value,
    input logic [twg_pkg::IDX_W-1:0]     o_sample_position,
    input logic                          o_period_end
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_compare_value) &&
            $stable(o_sample_position) && $stable(o_period_end))
        else $error("result payload changed while stalled");

    // period end marks exactly the last sample position
    a_period_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_period_end == (o_sample_position == twg_pkg::IDX_LAST)))
        else $error("period end flag does not match sample position");

    // one sample in work at a time: the strobe channel stalls after a transaction
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second strobe taken while a sample is in work");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind table_waveform_generator_core twg_checker u_twg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_compare_value   (o_compare_value),
    .o_sample_position (o_sample_position),
    .o_period_end      (o_period_end)
);
